/* rtl/core/lbps_pkg.sv */
// Shared types and constants of the light blink pattern sequencer.
package lbps_pkg;

  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;
  localparam int FUNC_W    = 3;
  localparam int CTIME_W   = 32;
  localparam int EIDX_W    = 4;
  localparam int TVAL_W    = 31;
  localparam int COLOR_W   = 32;
  localparam int RANGE_W   = 16;
  localparam int COUNT_W   = 5;

  localparam logic [COLOR_W-1:0] BLACK_RGBA = 32'h0000_00FF;

  // Register indexes, taken from paddr[3:2]
  localparam logic [1:0] REG_LIGHT_RANGE   = 2'd0;
  localparam logic [1:0] REG_LIGHT_PRESENT = 2'd1;
  localparam logic [1:0] REG_ENTRY_COUNT   = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_TICK         = 3'd0,
    FUNC_SWITCH_ON    = 3'd1,
    FUNC_SWITCH_OFF   = 3'd2,
    FUNC_SET_DURATION = 3'd3,
    FUNC_SET_INTERVAL = 3'd4,
    FUNC_SET_COLOR    = 3'd5
  } func_e;

  typedef struct packed {
    logic [RANGE_W-1:0] light_range;
    logic               light_present;
    logic [COUNT_W-1:0] entry_count;
  } cfg_t;

  typedef struct packed {
    func_e              func;
    logic [CTIME_W-1:0] current_time;
    logic [EIDX_W-1:0]  entry_index;
    logic               all_entries;
    logic [TVAL_W-1:0]  time_value;
    logic [COLOR_W-1:0] color_value;
  } item_t;

  typedef struct packed {
    logic               lit;
    logic [RANGE_W-1:0] range_out;
    logic [COLOR_W-1:0] color_out;
    logic               color_valid;
  } res_t;

endpackage

/* rtl/core/lbps_if.sv */
// Valid/ready channel interfaces for items and results.
interface lbps_in_if;
  logic                         valid;
  logic                         ready;
  logic [lbps_pkg::FUNC_W-1:0]  func;
  logic [lbps_pkg::CTIME_W-1:0] current_time;
  logic [lbps_pkg::EIDX_W-1:0]  entry_index;
  logic                         all_entries;
  logic [lbps_pkg::TVAL_W-1:0]  time_value;
  logic [lbps_pkg::COLOR_W-1:0] color_value;

  modport source (
    output valid, func, current_time, entry_index, all_entries, time_value, color_value,
    input  ready
  );
  modport sink (
    input  valid, func, current_time, entry_index, all_entries, time_value, color_value,
    output ready
  );
endinterface

interface lbps_out_if;
  logic                         valid;
  logic                         ready;
  logic                         lit;
  logic [lbps_pkg::RANGE_W-1:0] range_out;
  logic [lbps_pkg::COLOR_W-1:0] color_out;
  logic                         color_valid;

  modport source (
    output valid, lit, range_out, color_out, color_valid,
    input  ready
  );
  modport sink (
    input  valid, lit, range_out, color_out, color_valid,
    output ready
  );
endinterface

/* rtl/core/light_blink_pattern_sequencer.sv */
// Light blink pattern sequencer: input register, engine, result register, config port.
// The block takes one beat per clock cycle while its output is not stalled. An accepted
// beat waits in the input register, then the engine updates the pattern state and
// loads the result register at the same clock edge. While a result waits in the result
// register and the sink holds ready low, the input register holds its beat and the
// input stalls, whatever kind of beat is waiting. Tick beats give at most one result,
// switch and set beats none. The pattern table comes out of reset ready for use.
module light_blink_pattern_sequencer #(
  parameter int MAX_ENTRIES = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [lbps_pkg::PADDR_W-1:0] paddr,
  input  logic [lbps_pkg::PDATA_W-1:0] pwdata,
  output logic [lbps_pkg::PDATA_W-1:0] prdata,
  output logic                         pready,
  lbps_in_if.sink                      in_i,
  lbps_out_if.source                   out_o
);
  import lbps_pkg::*;

  cfg_t  cfg;
  item_t s1_item_q;
  logic  s1_valid_q;
  logic  can_take, advance, in_take;
  logic  res_valid;
  res_t  res;

  assign advance   = s1_valid_q && can_take;
  assign in_i.ready = !s1_valid_q || can_take;
  assign in_take   = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (advance) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_item_q.func         <= func_e'(in_i.func);
      s1_item_q.current_time <= in_i.current_time;
      s1_item_q.entry_index  <= in_i.entry_index;
      s1_item_q.all_entries  <= in_i.all_entries;
      s1_item_q.time_value   <= in_i.time_value;
      s1_item_q.color_value  <= in_i.color_value;
    end
  end

  lbps_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lbps_engine #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fire_i      (advance),
    .item_i      (s1_item_q),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  lbps_result_reg u_result (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (res_valid),
    .res_i      (res),
    .can_take_o (can_take),
    .out_o      (out_o)
  );

  a_stalled_item_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !can_take |=> s1_valid_q && $stable(s1_item_q))
    else $error("stalled beat lost or changed");

endmodule

/* rtl/core/lbps_cfg.sv */
// APB-style configuration registers.
module lbps_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [lbps_pkg::PADDR_W-1:0]   paddr,
  input  logic [lbps_pkg::PDATA_W-1:0]   pwdata,
  output logic [lbps_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready,
  output lbps_pkg::cfg_t                 cfg_o
);
  import lbps_pkg::*;

  cfg_t       cfg_q;
  logic [1:0] reg_idx;
  logic       wr_en;

  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign cfg_o   = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.light_range   <= '0;
      cfg_q.light_present <= 1'b1;
      cfg_q.entry_count   <= COUNT_W'(1);
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_LIGHT_RANGE:   cfg_q.light_range   <= pwdata[RANGE_W-1:0];
        REG_LIGHT_PRESENT: cfg_q.light_present <= pwdata[0];
        REG_ENTRY_COUNT:   cfg_q.entry_count   <= pwdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_LIGHT_RANGE:   prdata = PDATA_W'(cfg_q.light_range);
      REG_LIGHT_PRESENT: prdata = PDATA_W'(cfg_q.light_present);
      REG_ENTRY_COUNT:   prdata = PDATA_W'(cfg_q.entry_count);
      default:           prdata = '0;
    endcase
  end

endmodule

/* rtl/core/lbps_engine.sv */
// Pattern table, phase state and light decision for one item per cycle while fire_i is high.
module lbps_engine #(
  parameter int MAX_ENTRIES = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            fire_i,
  input  lbps_pkg::item_t item_i,
  input  lbps_pkg::cfg_t  cfg_i,
  output logic            res_valid_o,
  output lbps_pkg::res_t  res_o
);
  import lbps_pkg::*;

  localparam int IW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int NW  = $clog2(MAX_ENTRIES + 1);
  localparam int CW0 = (IW + 1 > NW) ? IW + 1 : NW;
  localparam int CW  = (CW0 > COUNT_W) ? CW0 : COUNT_W;
  localparam int PW  = (TIME_BITS < CTIME_W) ? TIME_BITS : CTIME_W;
  localparam int DW  = (PW > TVAL_W) ? PW : TVAL_W;
  localparam int SW  = DW + 2;

  logic [TVAL_W-1:0]  dur_q [MAX_ENTRIES];
  logic [TVAL_W-1:0]  int_q [MAX_ENTRIES];
  logic [COLOR_W-1:0] col_q [MAX_ENTRIES];

  logic [IW-1:0]      active_q, active_d;
  logic [PW-1:0]      start_q, start_d;
  logic               sw_q, sw_d;
  logic               lit_q, lit_d;
  logic [COLOR_W-1:0] held_q, held_d;
  logic               hv_q, hv_d;

  logic [MAX_ENTRIES-1:0] hit, dur_we, int_we, col_we;

  logic [CW-1:0]      cnt, n_eff, inc;
  logic [TVAL_W-1:0]  dur_cur, int_cur;
  logic [PW-1:0]      now, start_new;
  logic [SW-1:0]      end_sum;
  logic               ended, past;
  logic [IW-1:0]      nxt, sel;
  logic [COLOR_W-1:0] col;
  logic               do_light, do_dim;

  assign cnt   = CW'(cfg_i.entry_count);
  assign n_eff = (cnt == '0) ? CW'(1) :
                 (cnt > CW'(MAX_ENTRIES)) ? CW'(MAX_ENTRIES) : cnt;

  always_comb begin
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (item_i.all_entries) begin
        hit[i] = CW'(i) < n_eff;
      end else begin
        hit[i] = (CW'(item_i.entry_index) == CW'(i)) && (CW'(item_i.entry_index) < n_eff);
      end
    end
  end

  always_comb begin
    dur_cur   = dur_q[active_q];
    int_cur   = int_q[active_q];
    now       = item_i.current_time[PW-1:0];
    end_sum   = SW'(start_q) + SW'(dur_cur) + SW'(int_cur);
    ended     = (now < start_q) || (end_sum <= SW'(now));
    inc       = CW'(active_q) + CW'(1);
    nxt       = (inc >= n_eff) ? '0 : inc[IW-1:0];
    sel       = ended ? nxt : active_q;
    start_new = ended ? now : start_q;
    // a fresh phase is never past its duration
    past      = !ended && (DW'(now - start_q) > DW'(dur_cur));
    col       = col_q[sel];

    active_d = active_q;
    start_d  = start_q;
    sw_d     = sw_q;
    lit_d    = lit_q;
    held_d   = held_q;
    hv_d     = hv_q;
    dur_we   = '0;
    int_we   = '0;
    col_we   = '0;
    do_light = 1'b0;
    do_dim   = 1'b0;

    if (fire_i) begin
      case (item_i.func) inside
        FUNC_TICK: begin
          active_d = sel;
          start_d  = start_new;
          if (sw_q) begin
            if (past) begin
              do_dim = lit_q;
            end else if ((n_eff > CW'(1)) && (start_new == now)) begin
              do_light = 1'b1;
            end else begin
              do_light = !lit_q;
            end
          end else begin
            do_dim = lit_q;
          end
        end
        FUNC_SWITCH_ON:    sw_d   = 1'b1;
        FUNC_SWITCH_OFF:   sw_d   = 1'b0;
        FUNC_SET_DURATION: dur_we = hit;
        FUNC_SET_INTERVAL: int_we = hit;
        FUNC_SET_COLOR:    col_we = hit;
        default: ;
      endcase
    end

    if (do_light) begin
      lit_d = 1'b1;
      // black keeps the last real color
      if (col != BLACK_RGBA) begin
        held_d = col;
        hv_d   = 1'b1;
      end
    end
    if (do_dim) begin
      lit_d = 1'b0;
    end

    res_valid_o       = (do_light || do_dim) && cfg_i.light_present;
    res_o.lit         = do_light;
    res_o.range_out   = do_light ? cfg_i.light_range : '0;
    res_o.color_out   = held_d;
    res_o.color_valid = hv_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
      start_q  <= '0;
      sw_q     <= 1'b1;
      lit_q    <= 1'b1;
      held_q   <= '0;
      hv_q     <= 1'b0;
    end else begin
      active_q <= active_d;
      start_q  <= start_d;
      sw_q     <= sw_d;
      lit_q    <= lit_d;
      held_q   <= held_d;
      hv_q     <= hv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        dur_q[i] <= '0;
        int_q[i] <= '0;
        col_q[i] <= BLACK_RGBA;
      end
    end else begin
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        if (dur_we[i]) dur_q[i] <= item_i.time_value;
        if (int_we[i]) int_q[i] <= item_i.time_value;
        if (col_we[i]) col_q[i] <= item_i.color_value;
      end
    end
  end

  a_held_valid_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(hv_q) |-> hv_q)
    else $error("held color valid dropped");

  a_no_result_without_light: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> fire_i && (item_i.func == FUNC_TICK) && cfg_i.light_present)
    else $error("result from a non-tick item or absent light");

endmodule

/* rtl/core/lbps_result_reg.sv */
// Output register holding one result beat until it is taken.
module lbps_result_reg (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  lbps_pkg::res_t     res_i,
  output logic               can_take_o,
  lbps_out_if.source         out_o
);
  import lbps_pkg::*;

  logic valid_q;
  res_t res_q;

  assign can_take_o        = !valid_q || out_o.ready;
  assign out_o.valid       = valid_q;
  assign out_o.lit         = res_q.lit;
  assign out_o.range_out   = res_q.range_out;
  assign out_o.color_out   = res_q.color_out;
  assign out_o.color_valid = res_q.color_valid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_take_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_take_o && load_i) begin
      res_q <= res_i;
    end
  end

  a_dim_range_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.lit |-> res_q.range_out == '0)
    else $error("dimmed beat carries a range");

  a_no_color_before_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && !res_q.color_valid |-> res_q.color_out == '0)
    else $error("color reported before any was applied");

endmodule
